FILE: design/sft_pkg.sv
// shared constants and operation codes for the slot table insert unit
package sft_pkg;

  localparam int unsigned CAPACITY_DEF = 32;
  localparam int unsigned ID_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2
  } op_e;

endpackage

FILE: design/slot_table_first_free_insert_unit.sv
// slot table of particle ids with first-free push, first-match find and remove
//
//  channel   ports                                         handshake
//  command   start_i, func_i, particle_id_i                taken when start_i && !busy_o
//  result    found_o, slot_o, full_res_o, fill_count_o      one beat per command, done_o
//
//  a command scans the slot memory from slot 0 up to the fill length, one slot read
//  per cycle through the single read port, and stops at the first hit; the compare
//  acts on the registered read data in the cycle after the read, then the finishing
//  state writes back and registers the result. an empty table ends the scan with no
//  read, an unused code skips the scan; busy_o stays high for the whole command.
//  reset clears the fill length only: slots at or above it are never read, so the
//  memory needs no clearing pass. the receiver cannot stall the result beat.
module slot_table_first_free_insert_unit #(
  parameter int unsigned CAPACITY = sft_pkg::CAPACITY_DEF,
  parameter int unsigned ID_BITS  = sft_pkg::ID_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] particle_id_i,
  output logic        done_o,
  output logic        found_o,
  output logic [4:0]  slot_o,
  output logic        full_res_o,
  output logic [5:0]  fill_count_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned LEN_W = $clog2(CAPACITY + 1);
  localparam int unsigned ENT_W = ID_BITS + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  // slot memory: {valid, key}
  logic [ENT_W-1:0] mem_q [CAPACITY];
  logic [ENT_W-1:0] rdata_q;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;

  state_e           state_q, state_d;
  sft_pkg::op_e     op_q, op_d;
  logic [ID_BITS-1:0] key_q, key_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] rd_idx_q, rd_idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             hit_q, hit_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic             done_q, done_d;
  logic             found_q, found_d;
  logic [4:0]       slot_q, slot_d;
  logic             full_q, full_d;
  logic [5:0]       cnt_q, cnt_d;

  logic [31:0]      pid_ext;
  logic [31:0]      slot_ext;
  logic [31:0]      cnt_ext;
  logic [IDX_W-1:0] res_idx;
  logic             rd_valid;
  logic [ID_BITS-1:0] rd_key;
  logic             issue;
  logic             match;

  assign pid_ext  = 32'(particle_id_i);
  assign rd_valid = rdata_q[ID_BITS];
  assign rd_key   = rdata_q[ID_BITS-1:0];
  assign rd_addr  = rd_idx_q[IDX_W-1:0];
  assign slot_ext = 32'(res_idx);
  assign cnt_ext  = 32'(len_d);

  // push hunts for a hole, remove and find for a live matching key
  assign match = cmp_vld_q &&
                 ((op_q == sft_pkg::OP_PUSH) ? !rd_valid : (rd_valid && rd_key == key_q));
  assign issue = (state_q == S_SCAN) && (rd_idx_q < len_q) && !match;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    key_d     = key_q;
    len_d     = len_q;
    rd_idx_d  = rd_idx_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    done_d    = 1'b0;
    found_d   = found_q;
    slot_d    = slot_q;
    full_d    = full_q;
    cnt_d     = cnt_q;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = hit_idx_q;
    wr_data   = {1'b1, key_q};
    res_idx   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d     = sft_pkg::op_e'(func_i);
          key_d    = pid_ext[ID_BITS-1:0];
          rd_idx_d = '0;
          hit_d    = 1'b0;
          if (func_i == sft_pkg::OP_PUSH || func_i == sft_pkg::OP_REMOVE ||
              func_i == sft_pkg::OP_FIND) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SCAN: begin
        rd_en     = issue;
        cmp_vld_d = issue;
        cmp_idx_d = rd_addr;
        if (issue) begin
          rd_idx_d = rd_idx_q + LEN_W'(1);
        end
        if (match) begin
          hit_d     = 1'b1;
          hit_idx_d = cmp_idx_q;
          state_d   = S_DONE;
        end else if (!issue) begin
          hit_d   = 1'b0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        done_d  = 1'b1;
        found_d = 1'b0;
        full_d  = 1'b0;
        case (op_q)
          sft_pkg::OP_PUSH: begin
            if (hit_q) begin
              wr_en   = 1'b1;
              res_idx = hit_idx_q;
            end else if (len_q < LEN_W'(CAPACITY)) begin
              wr_en   = 1'b1;
              wr_addr = len_q[IDX_W-1:0];
              res_idx = len_q[IDX_W-1:0];
              len_d   = len_q + LEN_W'(1);
            end else begin
              full_d = 1'b1;
            end
          end
          sft_pkg::OP_REMOVE: begin
            if (hit_q) begin
              found_d = 1'b1;
              res_idx = hit_idx_q;
              wr_en   = 1'b1;
              wr_data = {1'b0, key_q};
              // only the topmost slot shrinks the fill length
              if (LEN_W'(hit_idx_q) + LEN_W'(1) == len_q) begin
                len_d = len_q - LEN_W'(1);
              end
            end
          end
          sft_pkg::OP_FIND: begin
            if (hit_q) begin
              found_d = 1'b1;
              res_idx = hit_idx_q;
            end
          end
          default: begin
          end
        endcase
        slot_d  = slot_ext[4:0];
        cnt_d   = cnt_ext[5:0];
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= sft_pkg::OP_PUSH;
      key_q     <= '0;
      len_q     <= '0;
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
      hit_q     <= 1'b0;
      hit_idx_q <= '0;
      done_q    <= 1'b0;
      found_q   <= 1'b0;
      slot_q    <= '0;
      full_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      key_q     <= key_d;
      len_q     <= len_d;
      rd_idx_q  <= rd_idx_d;
      cmp_vld_q <= cmp_vld_d;
      cmp_idx_q <= cmp_idx_d;
      hit_q     <= hit_d;
      hit_idx_q <= hit_idx_d;
      done_q    <= done_d;
      found_q   <= found_d;
      slot_q    <= slot_d;
      full_q    <= full_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign found_o      = found_q;
  assign slot_o       = slot_q;
  assign full_res_o   = full_q;
  assign fill_count_o = cnt_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(CAPACITY))
    else $error("fill length beyond capacity");

  a_done_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_DONE))
    else $error("result beat without a finishing cycle");

  a_cmp_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> state_q == S_SCAN)
    else $error("compare pending outside the scan");

  a_take_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("command taken but unit not busy");

  a_no_write_while_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> state_q == S_DONE)
    else $error("slot write outside the finishing cycle");

endmodule

FILE: tb/sv/slot_table_first_free_insert_unit_test.sv
// self-checking testbench for the slot table first-free insert unit
module slot_table_first_free_insert_unit_test;

  localparam int unsigned CAP           = sft_pkg::CAPACITY_DEF;
  localparam logic [1:0]  FUNC_UNUSED   = 2'd3;
  localparam int unsigned RANDOM_ITEMS  = 2000;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned STALL_LIMIT   = 4000;

  typedef struct packed {
    logic       found;
    logic [4:0] slot;
    logic       full_res;
    logic [5:0] fill_count;
  } slot_outcome_t;

  // shadow copy of the slot table and the outcomes still owed by the block
  class slot_table_shadow;
    logic [15:0]   keys [CAP];
    bit            held [CAP];
    int unsigned   fill_len;
    slot_outcome_t outcomes_due[$];
    int unsigned   errors;

    function new();
      fill_len = 0;
      errors   = 0;
      foreach (held[i]) held[i] = 1'b0;
    endfunction

    function void take_command(logic [1:0] func, logic [15:0] id);
      slot_outcome_t o;
      int unsigned   hit;
      o   = '0;
      hit = CAP;
      if (func == sft_pkg::OP_PUSH) begin
        for (int i = 0; i < fill_len; i++) begin
          if (!held[i]) begin
            hit = i;
            break;
          end
        end
        if (hit < CAP) begin
          keys[hit] = id;
          held[hit] = 1'b1;
          o.slot    = hit[4:0];
        end else if (fill_len < CAP) begin
          keys[fill_len] = id;
          held[fill_len] = 1'b1;
          o.slot         = fill_len[4:0];
          fill_len++;
        end else begin
          o.full_res = 1'b1;
        end
      end else if (func == sft_pkg::OP_REMOVE || func == sft_pkg::OP_FIND) begin
        for (int i = 0; i < fill_len; i++) begin
          if (held[i] && keys[i] == id) begin
            hit = i;
            break;
          end
        end
        if (hit < CAP) begin
          o.found = 1'b1;
          o.slot  = hit[4:0];
          if (func == sft_pkg::OP_REMOVE) begin
            held[hit] = 1'b0;
            // only the topmost slot shrinks the table
            if (hit + 1 == fill_len) fill_len--;
          end
        end
      end
      o.fill_count = fill_len[5:0];
      outcomes_due.push_back(o);
    endfunction

    function void compare_outcome(logic found, logic [4:0] slot, logic full_res,
                                  logic [5:0] fill_count);
      slot_outcome_t o;
      if (outcomes_due.size() == 0) begin
        $error("result beat with no command outstanding");
        errors++;
        return;
      end
      o = outcomes_due.pop_front();
      if (found !== o.found) begin
        $error("found: expected %0d, got %0d", o.found, found);
        errors++;
      end
      if (slot !== o.slot) begin
        $error("slot: expected %0d, got %0d", o.slot, slot);
        errors++;
      end
      if (full_res !== o.full_res) begin
        $error("full_res: expected %0d, got %0d", o.full_res, full_res);
        errors++;
      end
      if (fill_count !== o.fill_count) begin
        $error("fill_count: expected %0d, got %0d", o.fill_count, fill_count);
        errors++;
      end
    endfunction

    // a live id, else a random one when none is live, for hits on find and remove
    function logic [15:0] pick_held_key();
      int unsigned live[$];
      for (int i = 0; i < fill_len; i++) begin
        if (held[i]) live.push_back(i);
      end
      if (live.size() == 0) return 16'($urandom_range(0, 65535));
      return keys[live[$urandom_range(0, live.size() - 1)]];
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  func_i;
  logic [15:0] particle_id_i;
  logic        done_o;
  logic        found_o;
  logic [4:0]  slot_o;
  logic        full_res_o;
  logic [5:0]  fill_count_o;

  slot_table_shadow shadow;
  int unsigned      sender_idle_pct;
  int unsigned      quiet_cycles;

  slot_table_first_free_insert_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .func_i       (func_i),
    .particle_id_i(particle_id_i),
    .done_o       (done_o),
    .found_o      (found_o),
    .slot_o       (slot_o),
    .full_res_o   (full_res_o),
    .fill_count_o (fill_count_o)
  );

  always #5 clk_i = ~clk_i;

  // command and result beats are both seen here, command first
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) shadow.take_command(func_i, particle_id_i);
      if (done_o) shadow.compare_outcome(found_o, slot_o, full_res_o, fill_count_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // start may drop on any cycle while waiting, so gaps land in every phase
  task automatic send_command(logic [1:0] func, logic [15:0] id);
    func_i        <= func;
    particle_id_i <= id;
    forever begin
      start_i <= ($urandom_range(0, 99) >= sender_idle_pct);
      @(posedge clk_i);
      if (start_i && !busy_o) break;
      @(negedge clk_i);
    end
    @(negedge clk_i);
  endtask

  task automatic run_random(int unsigned items);
    int unsigned bias;
    int unsigned r;
    logic [1:0]  func;
    logic [15:0] id;
    bias = 2;
    for (int n = 0; n < items; n++) begin
      // pick fill-heavy, drain-heavy or mixed stretches at random to hit full and empty tables
      if (n % 80 == 0) bias = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      case (bias)
        0: begin
          func = (r < 60) ? sft_pkg::OP_PUSH : (r < 70) ? sft_pkg::OP_REMOVE :
                 (r < 95) ? sft_pkg::OP_FIND : FUNC_UNUSED;
        end
        1: begin
          func = (r < 15) ? sft_pkg::OP_PUSH : (r < 65) ? sft_pkg::OP_REMOVE :
                 (r < 95) ? sft_pkg::OP_FIND : FUNC_UNUSED;
        end
        default: begin
          func = (r < 35) ? sft_pkg::OP_PUSH : (r < 60) ? sft_pkg::OP_REMOVE :
                 (r < 95) ? sft_pkg::OP_FIND : FUNC_UNUSED;
        end
      endcase
      r = $urandom_range(0, 99);
      if (r < 55) begin
        id = shadow.pick_held_key();
      end else if (r < 70) begin
        case ($urandom_range(0, 3))
          0: id = 16'h0000;
          1: id = 16'hFFFF;
          2: id = 16'h0001;
          default: id = 16'h8000;
        endcase
      end else begin
        id = 16'($urandom_range(0, 65535));
      end
      send_command(func, id);
    end
  endtask

  initial begin
    shadow          = new();
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    func_i          = sft_pkg::OP_PUSH;
    particle_id_i   = '0;
    quiet_cycles    = 0;
    sender_idle_pct = 38;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // misses and the unused code on an empty table
    send_command(sft_pkg::OP_FIND, 16'h0000);
    send_command(sft_pkg::OP_REMOVE, 16'hFFFF);
    send_command(FUNC_UNUSED, 16'h1234);
    // duplicates, holes, hole refill, shrink from the top only
    send_command(sft_pkg::OP_PUSH, 16'hFFFF);
    send_command(sft_pkg::OP_PUSH, 16'h0000);
    send_command(sft_pkg::OP_PUSH, 16'hFFFF);
    send_command(sft_pkg::OP_FIND, 16'hFFFF);
    send_command(sft_pkg::OP_REMOVE, 16'h0000);
    send_command(sft_pkg::OP_FIND, 16'h0000);
    send_command(sft_pkg::OP_PUSH, 16'hA5A5);
    send_command(sft_pkg::OP_REMOVE, 16'hFFFF);
    send_command(sft_pkg::OP_FIND, 16'hFFFF);
    send_command(sft_pkg::OP_REMOVE, 16'hFFFF);
    send_command(sft_pkg::OP_REMOVE, 16'hA5A5);
    send_command(sft_pkg::OP_FIND, 16'h7FFF);
    send_command(sft_pkg::OP_PUSH, 16'h5A5A);
    send_command(FUNC_UNUSED, 16'hFFFF);
    send_command(sft_pkg::OP_REMOVE, 16'h5A5A);

    run_random(RANDOM_ITEMS / 3);
    sender_idle_pct = 68;
    run_random(RANDOM_ITEMS / 3);
    sender_idle_pct = 0;
    run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    start_i <= 1'b0;
    while (shadow.outcomes_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (shadow.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
